// ===== sv/ocb_pkg.sv =====
// ----------------------------------------------------------------------------
// Orientation coherence package
// Shared types, codes and constants for the orientation coherence block,
// plus the elaboration-time cosine generator used to build its lookup table.
// ----------------------------------------------------------------------------
package ocb_pkg;

  // Default sizes handed to the top level.
  localparam int DEF_MAX_DIM    = 64;
  localparam int DEF_ANGLE_BITS = 10;

  // Neighborhood geometry; the window is fixed at 5x5.
  localparam int WINDOW = 5;
  localparam int HALF   = WINDOW / 2;
  localparam int WIN_W  = $clog2(WINDOW);

  // Field and register widths.
  localparam int DIM_REG_W   = 7;
  localparam int THRESH_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int COH_W       = 16;
  localparam int BAND_W      = 2;

  // Register reset values.
  localparam logic [DIM_REG_W-1:0] RST_MAP_ROWS    = 7'd64;
  localparam logic [DIM_REG_W-1:0] RST_MAP_COLS    = 7'd64;
  localparam logic [THRESH_W-1:0]  RST_LOW_THRESH  = 16'd22938;
  localparam logic [THRESH_W-1:0]  RST_HIGH_THRESH = 16'd29491;

  // Accumulator: 25 Q1.15 values of at most 32768 need 20 bits.
  localparam int SUM_W   = 20;
  localparam int MAX_SUM = WINDOW * WINDOW * 32768;
  localparam int ROUND   = (WINDOW * WINDOW) / 2;

  // Division by 25 as a multiply by ceil(2^25 / 25), exact for sums below 1.8M.
  localparam int DIV_SHIFT = 25;
  localparam int RECIP_W   = 21;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 21'd1342178;

  // Cosine generator constants.
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int TAYLOR_TERMS = 11;

  // Input action codes.
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // Bandwidth classes.
  typedef enum logic [BAND_W-1:0] {
    BAND_PI      = 2'd0,
    BAND_HALF    = 2'd1,
    BAND_QUARTER = 2'd2
  } band_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAP_ROWS    = 2'd0,
    CFG_MAP_COLS    = 2'd1,
    CFG_LOW_THRESH  = 2'd2,
    CFG_HIGH_THRESH = 2'd3
  } cfg_reg_t;

  // Query sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  // Unsigned long division by shift and subtract; elaboration only.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos(e*pi/2^abits) in Q1.15 by a fixed-point Taylor series; elaboration only.
  function automatic logic [COH_W-1:0] cos_q15(input int unsigned e, input int unsigned abits);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned div;
    longint          sum;
    theta = (64'(e) * PI_Q30) >> abits;
    x2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = longint'(term);
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      div  = 64'((2 * k + 1) * (2 * k + 2));
      term = div_u64((term * x2) >> 30, div);
      if ((k & 1) != 0) begin
        sum = sum + longint'(term);
      end else begin
        sum = sum - longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return COH_W'((sum + 64'sd16384) >>> 15);
  endfunction

endpackage

// ===== sv/ocb_ram.sv =====
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic synchronous RAM with one address port and a registered read.
// ----------------------------------------------------------------------------
module ocb_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read share the address; read data appears in the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/orientation_coherence_bandwidth.sv =====
// A load word is taken in the idle state and the block is ready for the next word at once.
// A query word holds the input while it is processed: the accept cycle reads the centre, the
// scan state reads the window from the single-port RAM, the drain state empties the read pipe,
// then the divide and output states follow. A stalled earlier result holds the block in its
// output state. Reset clears the sequencer, the output valid and the configuration registers;
// the orientation RAM is not cleared.
// ----------------------------------------------------------------------------
// Orientation coherence and bandwidth class
// Keeps a block-orientation map in RAM, and for a query averages |cos| of the
// angle differences over a mirrored 5x5 neighborhood and classifies the result.
// ----------------------------------------------------------------------------
module orientation_coherence_bandwidth #(
  parameter int MAX_DIM    = ocb_pkg::DEF_MAX_DIM,
  parameter int ANGLE_BITS = ocb_pkg::DEF_ANGLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ocb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ocb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [$clog2(MAX_DIM)-1:0]        row,
  input  logic [$clog2(MAX_DIM)-1:0]        col,
  input  logic [ANGLE_BITS-1:0]             angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ocb_pkg::COH_W-1:0]         coherence,
  output logic [ocb_pkg::BAND_W-1:0]        band_class
);

  import ocb_pkg::*;

  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int ADDR_W      = $clog2(MAX_DIM * MAX_DIM);
  localparam int QUARTER_LEN = (1 << (ANGLE_BITS - 1)) + 1;
  localparam int E_W         = $clog2(QUARTER_LEN);
  localparam int SUMR_W      = SUM_W + 1;
  localparam int PROD_W      = SUMR_W + RECIP_W;

  typedef logic [COH_W-1:0] cos_tab_t [QUARTER_LEN];

  // Quarter-wave cosine table, built at elaboration.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t t;
    for (int e = 0; e < QUARTER_LEN; e++) begin
      t[e] = cos_q15(e, ANGLE_BITS);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  // Mirrored neighbor index: -1 -> 0, -2 -> 1, n -> n-1, n+1 -> n-2.
  function automatic logic [IDX_W-1:0] mirror_idx(input logic [IDX_W-1:0] base,
                                                  input logic [WIN_W-1:0] step,
                                                  input logic [DIM_W-1:0] n);
    logic signed [DIM_W+2:0] i;
    logic signed [DIM_W+2:0] nn;
    logic signed [DIM_W+2:0] r;
    i  = signed'((DIM_W+3)'(base)) + signed'((DIM_W+3)'(step)) - (DIM_W+3)'(HALF);
    nn = signed'((DIM_W+3)'(n));
    if (i < 0) begin
      r = -i - 1;
    end else if (i >= nn) begin
      r = (DIM_W+3)'(2 * nn - 1 - i);
    end else begin
      r = i;
    end
    return IDX_W'(r);
  endfunction

  // Circular code distance folded into 0..N/2.
  function automatic logic [E_W-1:0] fold_diff(input logic [ANGLE_BITS-1:0] a,
                                               input logic [ANGLE_BITS-1:0] c);
    logic [ANGLE_BITS-1:0] d;
    d = (a >= c) ? a - c : c - a;
    if (d > ANGLE_BITS'(1 << (ANGLE_BITS - 1))) begin
      d = -d;
    end
    return E_W'(d);
  endfunction

  // Configuration registers.
  logic [DIM_REG_W-1:0] map_rows;
  logic [DIM_REG_W-1:0] map_cols;
  logic [THRESH_W-1:0]  low_thresh;
  logic [THRESH_W-1:0]  high_thresh;

  // Sequencer and datapath registers.
  state_t               state;
  state_t               state_next;
  logic [IDX_W-1:0]     q_row;
  logic [IDX_W-1:0]     q_col;
  logic [WIN_W-1:0]     dr;
  logic [WIN_W-1:0]     dc;
  logic                 cen_v;
  logic                 rd_v;
  logic                 e_v;
  logic                 c_v;
  logic [ANGLE_BITS-1:0] centre;
  logic [E_W-1:0]       e_q;
  logic [COH_W-1:0]     cos_q;
  logic [SUM_W-1:0]     sum;
  logic [COH_W-1:0]     quot;

  // Combinational signals.
  logic [DIM_W-1:0]     used_rows;
  logic [DIM_W-1:0]     used_cols;
  logic                 in_range;
  logic                 accept;
  logic                 load_hit;
  logic                 query_hit;
  logic                 scan_last;
  logic                 out_load;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [ANGLE_BITS-1:0] ram_rdata;
  logic [IDX_W-1:0]     nb_row;
  logic [IDX_W-1:0]     nb_col;
  logic [SUMR_W-1:0]    sum_round;
  logic [PROD_W-1:0]    prod;
  band_t                band;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows    <= RST_MAP_ROWS;
      map_cols    <= RST_MAP_COLS;
      low_thresh  <= RST_LOW_THRESH;
      high_thresh <= RST_HIGH_THRESH;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MAP_ROWS:    map_rows    <= cfg_data[DIM_REG_W-1:0];
        CFG_MAP_COLS:    map_cols    <= cfg_data[DIM_REG_W-1:0];
        CFG_LOW_THRESH:  low_thresh  <= cfg_data[THRESH_W-1:0];
        CFG_HIGH_THRESH: high_thresh <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Map size saturated to 2..MAX_DIM.
  always_comb begin
    if (map_rows < DIM_REG_W'(2)) begin
      used_rows = DIM_W'(2);
    end else if (32'(map_rows) > MAX_DIM) begin
      used_rows = DIM_W'(MAX_DIM);
    end else begin
      used_rows = DIM_W'(map_rows);
    end
    if (map_cols < DIM_REG_W'(2)) begin
      used_cols = DIM_W'(2);
    end else if (32'(map_cols) > MAX_DIM) begin
      used_cols = DIM_W'(MAX_DIM);
    end else begin
      used_cols = DIM_W'(map_cols);
    end
  end

  // Input word decode; words for cells outside the map are dropped.
  assign accept    = in_valid && !in_stall;
  assign in_range  = (DIM_W'(row) < used_rows) && (DIM_W'(col) < used_cols);
  assign load_hit  = in_range && (action_t'(action) == ACT_LOAD);
  assign query_hit = in_range && (action_t'(action) == ACT_QUERY);
  assign scan_last = (dr == WIN_W'(WINDOW - 1)) && (dc == WIN_W'(WINDOW - 1));

  // Neighbor address for the current window position.
  assign nb_row = mirror_idx(q_row, dr, used_rows);
  assign nb_col = mirror_idx(q_col, dc, used_cols);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && query_hit) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v && !e_v && !c_v) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and RAM port.
  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    ram_addr = ADDR_W'(ADDR_W'(nb_row) * ADDR_W'(MAX_DIM) + ADDR_W'(nb_col));
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_we   = in_valid && load_hit;
        ram_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
      end
      ST_OUTPUT: begin
        out_load = !out_valid || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Orientation map storage.
  ocb_ram #(
    .WIDTH (ANGLE_BITS),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (angle),
    .rdata (ram_rdata)
  );

  // Window counters and read pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      dr    <= '0;
      dc    <= '0;
      cen_v <= 1'b0;
      rd_v  <= 1'b0;
      e_v   <= 1'b0;
      c_v   <= 1'b0;
    end else begin
      cen_v <= accept && query_hit;
      rd_v  <= (state == ST_SCAN);
      e_v   <= rd_v;
      c_v   <= e_v;
      if (accept) begin
        dr <= '0;
        dc <= '0;
      end else if (state == ST_SCAN) begin
        if (dc == WIN_W'(WINDOW - 1)) begin
          dc <= '0;
          dr <= dr + WIN_W'(1);
        end else begin
          dc <= dc + WIN_W'(1);
        end
      end
    end
  end

  // Datapath: capture centre, fold, table lookup, accumulate.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_row <= row;
      q_col <= col;
      sum   <= '0;
    end else if (c_v) begin
      sum <= sum + SUM_W'(cos_q);
    end
    if (cen_v) begin
      centre <= ram_rdata;
    end
    if (rd_v) begin
      e_q <= fold_diff(ram_rdata, centre);
    end
    if (e_v) begin
      cos_q <= COS_TAB[e_q];
    end
  end

  // Rounded divide by 25 through a reciprocal multiply.
  assign sum_round = SUMR_W'(sum) + SUMR_W'(ROUND);
  assign prod      = PROD_W'(sum_round) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE) begin
      quot <= COH_W'(prod >> DIV_SHIFT);
    end
  end

  // Bandwidth class; the low threshold wins.
  always_comb begin
    priority if (quot <= low_thresh) begin
      band = BAND_PI;
    end else if (quot >= high_thresh) begin
      band = BAND_QUARTER;
    end else begin
      band = BAND_HALF;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coherence  <= quot;
      band_class <= band;
    end
  end

  // A query word for a cell inside the map always starts a window scan.
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && query_hit) |=> (state == ST_SCAN))
    else $error("query word did not start a scan");

  // The RAM is written only by load words taken in the idle state.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE && accept))
    else $error("map write outside an accepted load word");

  // The read pipeline is empty before the divide.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (!rd_v && !e_v && !c_v))
    else $error("divide started with reads in flight");

  // The window sum never exceeds 25 full-scale cosines.
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (32'(sum) <= MAX_SUM))
    else $error("window sum out of range");

endmodule
